FILE: src/rrbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrbd_pkg;

  localparam int VALUE_BITS = 16;
  localparam int K_BITS = 4;
  localparam int ACC_BITS = 15;
  localparam int QUOT_BITS = 16;
  localparam int V_BITS = QUOT_BITS + ACC_BITS + 1;

  localparam logic [K_BITS-1:0] RICE_K_RESET = K_BITS'(2);
  localparam logic [QUOT_BITS-1:0] QUOT_MAX = {QUOT_BITS{1'b1}};

  localparam logic [V_BITS-1:0] MAX_POS = V_BITS'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
  localparam logic [V_BITS-1:0] MAX_NEG_MAG = V_BITS'(64'd1 << (VALUE_BITS - 1));
  localparam logic signed [VALUE_BITS-1:0] RES_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] RES_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EOS_REMAINDER = 2'd2;

  typedef struct packed {
    logic code_bit;
    logic end_of_stream;
  } bit_word_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] residual;
    logic [1:0] status;
  } res_word_t;

  typedef struct packed {
    logic fire;
    logic eos_err;
    logic [QUOT_BITS-1:0] quotient;
    logic [ACC_BITS-1:0] acc;
    logic ovf;
    logic [K_BITS-1:0] k;
  } step_t;

endpackage

`default_nettype wire

FILE: src/rrbd_word_state.sv
`timescale 1ns / 1ps
`default_nettype none

module rrbd_word_state (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rice_k_we,
  input  wire logic [rrbd_pkg::K_BITS-1:0]  rice_k,
  input  wire logic                         advance,
  input  wire rrbd_pkg::bit_word_t          word,
  output rrbd_pkg::step_t                   step
);

  logic [rrbd_pkg::K_BITS-1:0]    k_reg;
  logic [rrbd_pkg::K_BITS-1:0]    bits_left;
  logic [rrbd_pkg::K_BITS-1:0]    bits_left_next;
  logic [rrbd_pkg::ACC_BITS-1:0]  acc;
  logic [rrbd_pkg::ACC_BITS-1:0]  acc_next;
  logic [rrbd_pkg::QUOT_BITS-1:0] quotient;
  logic [rrbd_pkg::QUOT_BITS-1:0] quotient_next;
  logic                           ovf;
  logic                           ovf_next;
  logic                           unary;
  logic                           rearm;

  assign unary = (bits_left == '0);

  always_comb begin
    bits_left_next = bits_left;
    acc_next = acc;
    quotient_next = quotient;
    ovf_next = ovf;
    rearm = 1'b0;
    step.fire = 1'b0;
    step.eos_err = 1'b0;
    step.quotient = quotient;
    step.acc = acc;
    step.ovf = ovf;
    step.k = k_reg;
    if (advance) begin
      if (word.end_of_stream) begin
        rearm = 1'b1;
        if (unary) begin
          step.fire = !(k_reg == '0 && quotient == '0 && !ovf);
        end else if (bits_left < k_reg) begin
          step.fire = 1'b1;
          step.eos_err = 1'b1;
        end
      end else if (!unary) begin
        acc_next = {acc[rrbd_pkg::ACC_BITS-2:0], word.code_bit};
        bits_left_next = bits_left - rrbd_pkg::K_BITS'(1);
      end else if (word.code_bit) begin
        if (quotient == rrbd_pkg::QUOT_MAX) begin
          ovf_next = 1'b1;
        end else begin
          quotient_next = quotient + rrbd_pkg::QUOT_BITS'(1);
        end
      end else begin
        step.fire = 1'b1;
        rearm = 1'b1;
      end
    end
    if (rearm) begin
      bits_left_next = k_reg;
      acc_next = '0;
      quotient_next = '0;
      ovf_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= rrbd_pkg::RICE_K_RESET;
      bits_left <= rrbd_pkg::RICE_K_RESET;
      acc <= '0;
      quotient <= '0;
      ovf <= 1'b0;
    end else if (rice_k_we) begin
      k_reg <= rice_k;
      bits_left <= rice_k;
      acc <= '0;
      quotient <= '0;
      ovf <= 1'b0;
    end else begin
      bits_left <= bits_left_next;
      acc <= acc_next;
      quotient <= quotient_next;
      ovf <= ovf_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/rrbd_value_map.sv
`timescale 1ns / 1ps
`default_nettype none

module rrbd_value_map (
  input  wire rrbd_pkg::step_t step,
  output rrbd_pkg::res_word_t  word
);

  logic [rrbd_pkg::V_BITS-1:0] v;
  logic [rrbd_pkg::V_BITS-1:0] mag;
  logic [rrbd_pkg::V_BITS-1:0] neg_mag;
  logic                        neg;

  assign v = (rrbd_pkg::V_BITS'(step.quotient) << step.k) + rrbd_pkg::V_BITS'(step.acc);
  assign neg = v[0];
  assign mag = {1'b0, v[rrbd_pkg::V_BITS-1:1]} + rrbd_pkg::V_BITS'(neg);
  assign neg_mag = '0 - mag;

  always_comb begin
    word.residual = '0;
    word.status = rrbd_pkg::ST_OK;
    if (step.eos_err) begin
      word.status = rrbd_pkg::ST_EOS_REMAINDER;
    end else if (neg) begin
      if (step.ovf || mag > rrbd_pkg::MAX_NEG_MAG) begin
        word.residual = rrbd_pkg::RES_MIN;
        word.status = rrbd_pkg::ST_OVERFLOW;
      end else begin
        word.residual = neg_mag[rrbd_pkg::VALUE_BITS-1:0];
      end
    end else begin
      if (step.ovf || mag > rrbd_pkg::MAX_POS) begin
        word.residual = rrbd_pkg::RES_MAX;
        word.status = rrbd_pkg::ST_OVERFLOW;
      end else begin
        word.residual = mag[rrbd_pkg::VALUE_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/rice_residual_bit_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Golomb-Rice residual decoder with zigzag sign unmapping.
// The bit channel (bit_valid, bit_ready, bit_word) takes one coded stream bit per word,
// or a stream end marker. The result channel (res_valid, res_ready, res_word) gives a
// signed residual and a status for each completed code word.
// The Rice parameter is written through rice_k_we and rice_k, only while the block is idle:
// a rule for the user that the block does not enforce. A write drops any partly read code word.
// A bit word is taken into an input register, decoded against the code word state once the
// output register is free or being read, and any result lands in the output register.
// Throughput is one bit word per cycle while the result channel does not stall: each word updates
// the code word state (remainder shift, quotient count); the shift-add value mapping is combinational.
// Most bit words produce no result; a result appears only on a closing zero or a stream end.
// When the receiver stalls, the held result stays in the output register and the input
// register can still fill, so one more word is taken before bit_ready falls.
// Synchronous reset sets the Rice parameter to two and clears both registers and the
// code word state; there is no clearing pass.

module rice_residual_bit_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            rice_k_we,
  input  wire logic [rrbd_pkg::K_BITS-1:0]     rice_k,
  input  wire logic                            bit_valid,
  output logic                                 bit_ready,
  input  wire rrbd_pkg::bit_word_t             bit_word,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output rrbd_pkg::res_word_t                  res_word
);

  logic                in_full;
  rrbd_pkg::bit_word_t in_word;
  logic                advance;
  rrbd_pkg::step_t     step;
  rrbd_pkg::res_word_t mapped;

  assign advance = in_full && (!res_valid || res_ready);
  assign bit_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (bit_valid && bit_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bit_valid && bit_ready) begin
      in_word <= bit_word;
    end
  end

  rrbd_word_state u_word_state (
    .clk       (clk),
    .rst       (rst),
    .rice_k_we (rice_k_we),
    .rice_k    (rice_k),
    .advance   (advance),
    .word      (in_word),
    .step      (step)
  );

  rrbd_value_map u_value_map (
    .step (step),
    .word (mapped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step.fire;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.fire) begin
      res_word <= mapped;
    end
  end

  a_no_advance_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !advance)
    else $error("decoder advanced while a result word was stalled");

  a_eos_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.status == rrbd_pkg::ST_EOS_REMAINDER) |-> (res_word.residual == '0))
    else $error("stream end inside remainder gave a nonzero residual");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.status == rrbd_pkg::ST_OVERFLOW) |->
      (res_word.residual == rrbd_pkg::RES_MAX || res_word.residual == rrbd_pkg::RES_MIN))
    else $error("overflow status without a saturated residual");

  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !bit_ready |-> in_full)
    else $error("bit_ready low with an empty input register");

endmodule

`default_nettype wire
